// ===== hw/rtl/dlpm_pkg.sv =====
`timescale 1ns / 1ps

package dlpm_pkg;

	// Widths fixed by the item fields.
	localparam int unsigned STATE_BITS  = 8;
	localparam int unsigned CHAR_BITS   = 7;
	localparam int unsigned KIND_BITS   = 2;
	localparam int unsigned BRANCH_BITS = 4;
	localparam int unsigned LENGTH_BITS = 16;

	// Table geometry.
	localparam int unsigned STATE_COUNT  = 256;
	localparam int unsigned CHAR_COUNT   = 128;
	localparam int unsigned BRANCH_COUNT = 15;
	localparam int unsigned TRANS_DEPTH  = STATE_COUNT * CHAR_COUNT;

	// Result queue.
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
	localparam int unsigned LEVEL_BITS = $clog2(FIFO_DEPTH + 1);

	// Item kinds.
	localparam logic [KIND_BITS-1:0] KIND_TRANS  = 2'd0;
	localparam logic [KIND_BITS-1:0] KIND_ACTION = 2'd1;
	localparam logic [KIND_BITS-1:0] KIND_TEXT   = 2'd2;

	typedef struct packed {
		logic                   dead;
		logic [BRANCH_BITS-1:0] branch;
	} act_t;

	typedef struct packed {
		logic [LENGTH_BITS-1:0] match_length;
		logic [BRANCH_BITS-1:0] match_branch;
		logic                   hit_dead_state;
	} res_t;

endpackage

// ===== hw/rtl/dlpm_in_if.sv =====
`timescale 1ns / 1ps

interface dlpm_in_if import dlpm_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [KIND_BITS-1:0]   kind;
	logic [STATE_BITS-1:0]  state_index;
	logic [CHAR_BITS-1:0]   char_code;
	logic [STATE_BITS-1:0]  next_state;
	logic                   dead_mark;
	logic [BRANCH_BITS-1:0] good_branch;
	logic                   last_char;

	modport source (
		output valid, kind, state_index, char_code, next_state, dead_mark, good_branch,
		last_char,
		input  ready
	);
	modport sink (
		input  valid, kind, state_index, char_code, next_state, dead_mark, good_branch,
		last_char,
		output ready
	);
endinterface

// ===== hw/rtl/dlpm_out_if.sv =====
`timescale 1ns / 1ps

interface dlpm_out_if import dlpm_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [LENGTH_BITS-1:0] match_length;
	logic [BRANCH_BITS-1:0] match_branch;
	logic                   hit_dead_state;

	modport source (
		output valid, match_length, match_branch, hit_dead_state,
		input  ready
	);
	modport sink (
		input  valid, match_length, match_branch, hit_dead_state,
		output ready
	);
endinterface

// ===== hw/rtl/dlpm_out_fifo.sv =====
`timescale 1ns / 1ps

// Small result queue that parts the scan pipeline from the result consumer.
module dlpm_out_fifo import dlpm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  res_t                  push_data,
	output logic [LEVEL_BITS-1:0] level,
	dlpm_out_if.source            results
);

	res_t                     slot_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] wr_ptr_q;
	logic [FIFO_PTR_BITS-1:0] rd_ptr_q;
	logic [LEVEL_BITS-1:0]    level_q;
	logic                     pop;

	assign pop   = results.valid && results.ready;
	assign level = level_q;

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   level_q <= level_q + 1'b1;
				2'b01:   level_q <= level_q - 1'b1;
				default: level_q <= level_q;
			endcase
		end
	end

	assign results.valid          = (level_q != '0);
	assign results.match_length   = slot_q[rd_ptr_q].match_length;
	assign results.match_branch   = slot_q[rd_ptr_q].match_branch;
	assign results.hit_dead_state = slot_q[rd_ptr_q].hit_dead_state;

endmodule

// ===== hw/rtl/dfa_longest_prefix_matcher_unit.sv =====
`timescale 1ns / 1ps

// Channel  | Dir | Word carried
// ---------+-----+---------------------------------------------------------------
// items    | in  | kind, state_index, char_code, next_state, dead_mark, good_branch,
//          |     | last_char: one table write or one text character per word
// results  | out | match_length, match_branch, hit_dead_state: one word per text
//
// One input word is taken every cycle while the input is not held off. A text
// character passes the transition memory read, then the action memory read of
// the state reached; a final character's result enters a four-word output queue.
// The input is held off, for every word kind, while the queue plus the final
// characters still in the pipeline would fill the queue; a receiver that is ready
// every cycle never causes a stall.
// Reset clears the scan registers and the pipeline; both tables are undefined
// until loaded and get no clearing pass.
module dfa_longest_prefix_matcher_unit import dlpm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	dlpm_in_if.sink    items,
	dlpm_out_if.source results
);

	localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

	// Decode of the accepted word.
	logic accept;
	logic trans_we;
	logic act_we;
	logic text_acc;

	assign accept = items.valid && items.ready;

	always_comb begin
		trans_we = 1'b0;
		act_we   = 1'b0;
		text_acc = 1'b0;
		case (items.kind)
			KIND_TRANS:  trans_we = accept;
			KIND_ACTION: act_we   = accept && (items.good_branch <= BRANCH_COUNT);
			KIND_TEXT:   text_acc = accept;
			default:     ;
		endcase
	end

	// The transition memory is addressed by the current state and the character.
	// The state for a character that directly follows another comes straight from
	// the memory's read register, so consecutive characters chain without a bubble.
	// A character that follows a final one starts again from state zero.
	logic [STATE_BITS-1:0] trans_mem [TRANS_DEPTH];
	logic [STATE_BITS-1:0] trans_rd;
	logic [STATE_BITS-1:0] cur_q;
	logic [STATE_BITS-1:0] scan_state;
	logic                  s1_valid;
	logic                  s1_last;

	always_comb begin
		if (s1_valid) begin
			scan_state = s1_last ? '0 : trans_rd;
		end else begin
			scan_state = cur_q;
		end
	end

	always_ff @(posedge clk) begin
		if (trans_we) trans_mem[{items.state_index, items.char_code}] <= items.next_state;
		if (text_acc) trans_rd <= trans_mem[{scan_state, items.char_code}];
	end

	// The action memory is read with the state just reached. A write that lands
	// on the same edge as that read is a later word, so the read sees the old
	// entry, which is what the word order demands.
	act_t act_mem [STATE_COUNT];
	act_t act_rd;

	always_ff @(posedge clk) begin
		if (act_we) act_mem[items.state_index] <= '{dead: items.dead_mark,
			branch: items.good_branch};
		if (s1_valid) act_rd <= act_mem[trans_rd];
	end

	// Pipeline control.
	logic s2_valid;
	logic s2_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			s1_last  <= 1'b0;
			s2_valid <= 1'b0;
			s2_last  <= 1'b0;
			cur_q    <= '0;
		end else begin
			s1_valid <= text_acc;
			s1_last  <= items.last_char;
			s2_valid <= s1_valid;
			s2_last  <= s1_last;
			cur_q    <= scan_state;
		end
	end

	// Scan bookkeeping, applied in text order at the second stage. Once the scan
	// has died, characters still in flight leave these registers alone; a final
	// character still reports and clears them.
	logic [LENGTH_BITS-1:0] pos_q;
	logic [LENGTH_BITS-1:0] best_len_q;
	logic [BRANCH_BITS-1:0] best_br_q;
	logic                   dead_q;
	logic [LENGTH_BITS-1:0] pos_n;
	logic [LENGTH_BITS-1:0] best_len_n;
	logic [BRANCH_BITS-1:0] best_br_n;
	logic                   dead_n;

	always_comb begin
		pos_n      = pos_q;
		best_len_n = best_len_q;
		best_br_n  = best_br_q;
		dead_n     = dead_q;
		if (!dead_q) begin
			if (pos_q != LEN_MAX) pos_n = pos_q + 1'b1;
			if (act_rd.dead) begin
				dead_n = 1'b1;
			end else if (act_rd.branch != '0) begin
				best_br_n  = act_rd.branch;
				best_len_n = pos_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			best_len_q <= '0;
			best_br_q  <= '0;
			dead_q     <= 1'b0;
		end else if (s2_valid) begin
			if (s2_last) begin
				pos_q      <= '0;
				best_len_q <= '0;
				best_br_q  <= '0;
				dead_q     <= 1'b0;
			end else begin
				pos_q      <= pos_n;
				best_len_q <= best_len_n;
				best_br_q  <= best_br_n;
				dead_q     <= dead_n;
			end
		end
	end

	// Result queue and input credit.
	logic                  push;
	res_t                  push_data;
	logic [LEVEL_BITS-1:0] level;
	logic [LEVEL_BITS-1:0] in_flight;

	assign push      = s2_valid && s2_last;
	assign push_data = '{match_length: best_len_n, match_branch: best_br_n,
		hit_dead_state: dead_n};

	dlpm_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.level     (level),
		.results   (results)
	);

	assign in_flight   = LEVEL_BITS'(s1_valid && s1_last) + LEVEL_BITS'(s2_valid && s2_last);
	assign items.ready = (level + in_flight) < LEVEL_BITS'(FIFO_DEPTH);

endmodule

// ===== hw/rtl/dlpm_checker.sv =====
`timescale 1ns / 1ps

module dlpm_checker import dlpm_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic [KIND_BITS-1:0]   in_kind,
	input logic                   in_last,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [LENGTH_BITS-1:0] out_length,
	input logic [BRANCH_BITS-1:0] out_branch,
	input logic                   out_dead
);

	// Final characters taken whose result words have not yet been delivered.
	logic [LEVEL_BITS-1:0] owed_q;
	logic                  owe_inc;
	logic                  owe_dec;

	assign owe_inc = in_valid && in_ready && (in_kind == KIND_TEXT) && in_last;
	assign owe_dec = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_q <= '0;
		end else if (owe_inc && !owe_dec) begin
			owed_q <= owed_q + 1'b1;
		end else if (owe_dec && !owe_inc) begin
			owed_q <= owed_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word withdrawn while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			$stable(out_length) && $stable(out_branch) && $stable(out_dead))
		else $error("result word changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> owed_q != '0)
		else $error("result word shown with no final character owed");

	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		owed_q <= LEVEL_BITS'(FIFO_DEPTH))
		else $error("more results owed than the output queue can hold");

endmodule

bind dfa_longest_prefix_matcher_unit dlpm_checker u_dlpm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (items.valid),
	.in_ready   (items.ready),
	.in_kind    (items.kind),
	.in_last    (items.last_char),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.out_length (results.match_length),
	.out_branch (results.match_branch),
	.out_dead   (results.hit_dead_state)
);
